// ===== rtl/core/tsmv_pkg.sv =====
`default_nettype none

package tsmv_pkg;

	// Width of the column counters; widths below derive from it.
	localparam int COLUMN_BITS = 16;
	localparam int CMP_W       = (COLUMN_BITS + 1 > 17) ? COLUMN_BITS + 1 : 17;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam logic [7:0] CH_NL       = 8'h0a;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7e;

	// Tab stops are a power of two apart.
	localparam int TAB_STOP = 4;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_TOO_LONG = 2'd2,
		ST_TOO_MANY = 2'd3
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_EDITOR_MODE  = 2'd0,
		REG_COLUMN_LIMIT = 2'd1,
		REG_LINE_LIMIT   = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/text_source_measure_validator_core.sv =====
`default_nettype none

// Channel   Handshake                Payload
// input     in_valid / in_ready      func, data_byte
// output    out_valid / out_ready    result_status, byte_count, line_count,
//                                    widest_line, text_hash
// config    cfg_we                   cfg_index, cfg_data
//
// One item per cycle while no end marker waits: a transfer lands in the input
// register; from there it updates the line/hash state (one constant multiply
// for the hash) and, for an end marker, loads the result register, which raises
// out_valid. An end marker waits in the input register while the result
// register still holds an untaken result; byte items never wait.
// Reset is asynchronous and resets the measurement state, config and valids.

module text_source_measure_validator_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 func,
	input  wire logic [7:0]                           data_byte,

	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [1:0]                                result_status,
	output logic [31:0]                               byte_count,
	output logic [31:0]                               line_count,
	output logic [15:0]                               widest_line,
	output logic [31:0]                               text_hash,

	input  wire logic                                 cfg_we,
	input  wire logic [tsmv_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [tsmv_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CB    = tsmv_pkg::COLUMN_BITS;
	localparam int CMP_W = tsmv_pkg::CMP_W;

	// configuration
	logic        editor_q;
	logic [15:0] col_limit_q;
	logic [15:0] line_limit_q;

	// input register
	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;

	// measurement state
	logic [CB-1:0]     col_q, col_n;
	logic [CB-1:0]     max_col_q, max_col_n;
	logic [31:0]       lines_q, lines_n;
	logic [31:0]       bytes_q, bytes_n;
	logic [31:0]       hash_q, hash_n;
	logic              bol_q, bol_n;
	tsmv_pkg::status_t err_q, err_n;

	// result register
	logic              out_valid_q, out_valid_n;
	tsmv_pkg::status_t res_status_q, res_status_n;
	logic [31:0]       res_bytes_q, res_bytes_n;
	logic [31:0]       res_lines_q, res_lines_n;
	logic [15:0]       res_widest_q, res_widest_n;
	logic [31:0]       res_hash_q, res_hash_n;

	logic              adv_s1;
	logic              end_go;
	logic [31:0]       hash_x;
	logic [31:0]       hash_mul;
	logic [CMP_W-1:0]  next_col;
	logic [CMP_W-1:0]  max_wide;
	logic [15:0]       widest_cap;
	logic              is_tab;
	logic              is_print;
	tsmv_pkg::status_t end_status;

	// An end marker moves only when the result register is free or drains.
	assign adv_s1   = valid_s1 && (func_s1 == tsmv_pkg::FUNC_BYTE || !out_valid_q || out_ready);
	assign end_go   = adv_s1 && func_s1 == tsmv_pkg::FUNC_END;
	assign in_ready = !valid_s1 || adv_s1;

	assign hash_x   = hash_q ^ {24'd0, byte_s1};
	assign hash_mul = hash_x * tsmv_pkg::FNV_PRIME;

	assign is_tab   = editor_q && byte_s1 == tsmv_pkg::CH_TAB;
	assign is_print = byte_s1 >= tsmv_pkg::CH_PRINT_LO && byte_s1 <= tsmv_pkg::CH_PRINT_HI;

	assign max_wide   = CMP_W'(max_col_q);
	assign widest_cap = (max_wide > CMP_W'(16'hffff)) ? 16'hffff : max_wide[15:0];

	always_comb begin
		next_col = CMP_W'(col_q) + CMP_W'(1);
		if (is_tab) begin
			next_col = CMP_W'(col_q & ~CB'(tsmv_pkg::TAB_STOP - 1)) + CMP_W'(tsmv_pkg::TAB_STOP);
		end
	end

	always_comb begin
		end_status = err_q;
		if (err_q == tsmv_pkg::ST_OK && !editor_q && lines_q > {16'd0, line_limit_q}) begin
			end_status = tsmv_pkg::ST_TOO_MANY;
		end
	end

	always_comb begin
		col_n     = col_q;
		max_col_n = max_col_q;
		lines_n   = lines_q;
		bytes_n   = bytes_q;
		hash_n    = hash_q;
		bol_n     = bol_q;
		err_n     = err_q;

		if (adv_s1) begin
			if (func_s1 == tsmv_pkg::FUNC_END) begin
				col_n     = '0;
				max_col_n = '0;
				lines_n   = '0;
				bytes_n   = '0;
				hash_n    = tsmv_pkg::FNV_BASIS;
				bol_n     = 1'b1;
				err_n     = tsmv_pkg::ST_OK;
			end else if (err_q == tsmv_pkg::ST_OK) begin
				if (bol_q) begin
					lines_n = (lines_q == '1) ? lines_q : lines_q + 32'd1;
					bol_n   = 1'b0;
				end
				bytes_n = (bytes_q == '1) ? bytes_q : bytes_q + 32'd1;
				hash_n  = hash_mul;
				priority if (byte_s1 == tsmv_pkg::CH_NL) begin
					col_n = '0;
					bol_n = 1'b1;
				end else if (is_tab || is_print) begin
					// saturate at the counter's full scale
					col_n = next_col[CB] ? '1 : next_col[CB-1:0];
					if (col_n > max_col_q) begin
						max_col_n = col_n;
					end
					if (!editor_q && next_col > CMP_W'(col_limit_q)) begin
						err_n = tsmv_pkg::ST_TOO_LONG;
					end
				end else begin
					err_n = tsmv_pkg::ST_BAD_CHAR;
				end
			end
		end
	end

	always_comb begin
		out_valid_n  = out_valid_q && !out_ready;
		res_status_n = res_status_q;
		res_bytes_n  = res_bytes_q;
		res_lines_n  = res_lines_q;
		res_widest_n = res_widest_q;
		res_hash_n   = res_hash_q;
		if (end_go) begin
			out_valid_n  = 1'b1;
			res_status_n = end_status;
			if (end_status == tsmv_pkg::ST_OK) begin
				res_bytes_n  = bytes_q;
				res_lines_n  = lines_q;
				res_widest_n = widest_cap;
				res_hash_n   = hash_q;
			end else begin
				res_bytes_n  = '0;
				res_lines_n  = '0;
				res_widest_n = '0;
				res_hash_n   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			editor_q     <= 1'b0;
			col_limit_q  <= 16'd80;
			line_limit_q <= 16'd23;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsmv_pkg::REG_EDITOR_MODE:  editor_q     <= cfg_data[0];
				tsmv_pkg::REG_COLUMN_LIMIT: col_limit_q  <= cfg_data[15:0];
				tsmv_pkg::REG_LINE_LIMIT:   line_limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			max_col_q   <= '0;
			lines_q     <= '0;
			bytes_q     <= '0;
			hash_q      <= tsmv_pkg::FNV_BASIS;
			bol_q       <= 1'b1;
			err_q       <= tsmv_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			col_q       <= col_n;
			max_col_q   <= max_col_n;
			lines_q     <= lines_n;
			bytes_q     <= bytes_n;
			hash_q      <= hash_n;
			bol_q       <= bol_n;
			err_q       <= err_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_ff @(posedge clk) begin
		res_status_q <= res_status_n;
		res_bytes_q  <= res_bytes_n;
		res_lines_q  <= res_lines_n;
		res_widest_q <= res_widest_n;
		res_hash_q   <= res_hash_n;
	end

	assign out_valid     = out_valid_q;
	assign result_status = res_status_q;
	assign byte_count    = res_bytes_q;
	assign line_count    = res_lines_q;
	assign widest_line   = res_widest_q;
	assign text_hash     = res_hash_q;

	// a result that is still held blocks a pending end marker
	a_end_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && valid_s1 && func_s1 == tsmv_pkg::FUNC_END) |-> !in_ready)
		else $error("end marker advanced over a held result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_status_q != tsmv_pkg::ST_OK) |->
		(res_bytes_q == '0 && res_lines_q == '0 && res_widest_q == '0 && res_hash_q == '0))
		else $error("error result carries nonzero metrics");

	a_err_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != tsmv_pkg::ST_OK && !end_go) |=> (err_q == $past(err_q)))
		else $error("latched error changed before end of source");

	a_bol_col: assert property (@(posedge clk) disable iff (!arst_n)
		bol_q |-> col_q == '0)
		else $error("column nonzero at line start");

endmodule

`default_nettype wire
